// File: rtl/core/mptc_pkg.sv
`timescale 1ns / 1ps

package mptc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int PWM_W       = 16;
    localparam int TIME_W      = 32;
    localparam int WIN_W       = 5;
    localparam int SUM_W       = PWM_W + $clog2(MAX_ENTRIES);
    localparam int PROD_W      = TIME_W + PWM_W;
    localparam int DIV_STEPS   = PWM_W;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [TIME_W-1:0] TARGET_RST = 32'd60000;
    localparam logic [PWM_W-1:0]  INC_RST    = 16'd10;
    localparam logic [WIN_W-1:0]  WIN_RST    = 5'd9;
    localparam logic [PWM_W-1:0]  INIT_RST   = 16'd0;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TIME     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_INCREMENT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PWM     = 8'd3;

    typedef struct packed {
        logic [TIME_W-1:0] actual_time;
        logic [PWM_W-1:0]  current_pwm;
        logic              top_reached;
    } in_t;

    typedef struct packed {
        logic [PWM_W-1:0] corrected_pwm;
        logic [PWM_W-1:0] mean_pwm;
    } out_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_corr;
        logic corr;
        logic upd;
        logic div_mean;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/mptc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit a cycle. The caller guarantees that
// rem_init < divisor, so the quotient fits in PWM_W bits.
module mptc_div
    import mptc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TIME_W-1:0] rem_init,
    input  logic [PWM_W-1:0]  dividend_lo,
    input  logic [TIME_W-1:0] divisor,
    output logic              done,
    output logic [PWM_W-1:0]  quot
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] div_reg;
    logic [PWM_W-1:0]  quo_reg;

    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;

    assign trial = {rem_reg, quo_reg[PWM_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            div_reg <= divisor;
            quo_reg <= dividend_lo;
        end else if (busy_reg) begin
            if (!diff[TIME_W]) begin
                rem_reg <= diff[TIME_W-1:0];
                quo_reg <= {quo_reg[PWM_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[TIME_W-1:0];
                quo_reg <= {quo_reg[PWM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// File: rtl/core/mptc_ctrl.sv
`timescale 1ns / 1ps

module mptc_ctrl
    import mptc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_STC  = 4'd2;
    localparam logic [3:0] ST_DIVC = 4'd3;
    localparam logic [3:0] ST_CORR = 4'd4;
    localparam logic [3:0] ST_UPD  = 4'd5;
    localparam logic [3:0] ST_STM  = 4'd6;
    localparam logic [3:0] ST_DIVM = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_STC;
            end
            ST_STC: begin
                cmd.div_corr = 1'b1;
                state_next   = ST_DIVC;
            end
            ST_DIVC: begin
                if (sts.div_done) begin
                    state_next = ST_CORR;
                end
            end
            ST_CORR: begin
                cmd.corr   = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_STM;
            end
            ST_STM: begin
                cmd.div_mean = 1'b1;
                state_next   = ST_DIVM;
            end
            ST_DIVM: begin
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/mptc_dp.sv
`timescale 1ns / 1ps

module mptc_dp
    import mptc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    // configuration
    logic [TIME_W-1:0] target_reg;
    logic [PWM_W-1:0]  inc_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [PWM_W-1:0]  init_reg;

    // item working set
    logic [TIME_W-1:0] diff_reg;
    logic              less_reg;
    logic [PWM_W-1:0]  pwm_reg;
    logic              top_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PWM_W-1:0]  corr_reg;
    logic [PWM_W-1:0]  old_reg;

    // ring state
    logic [PWM_W-1:0]  ring [MAX_ENTRIES];
    logic [SLOT_W-1:0] slot_reg;
    logic              full_reg;
    logic [SUM_W-1:0]  sum_reg;

    logic              m_valid_reg;
    out_t              m_data_reg;

    logic              wr_target;
    logic              wr_inc;
    logic              wr_win;
    logic              wr_init;
    logic              restart;
    logic [PWM_W-1:0]  restart_pwm;

    logic [CNT_W-1:0]  win_eff;
    logic [CNT_W-1:0]  mean_cnt;
    logic [SLOT_W-1:0] slot_adv;
    logic              wrap;
    logic [TIME_W:0]   sub_wide;

    logic              ring_we;
    logic [SLOT_W-1:0] ring_waddr;
    logic [PWM_W-1:0]  ring_wdata;

    logic              div_start;
    logic [TIME_W-1:0] div_rem;
    logic [PWM_W-1:0]  div_lo;
    logic [TIME_W-1:0] div_den;
    logic              div_done;
    logic [PWM_W-1:0]  div_q;

    assign cfg_ready = aresetn;

    always_comb begin
        wr_target = 1'b0;
        wr_inc    = 1'b0;
        wr_win    = 1'b0;
        wr_init   = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_TARGET_TIME:     wr_target = 1'b1;
                REG_SPEED_INCREMENT: wr_inc    = 1'b1;
                REG_WINDOW_SIZE:     wr_win    = 1'b1;
                REG_INITIAL_PWM:     wr_init   = 1'b1;
                default: ;
            endcase
        end
    end

    assign restart     = wr_win | wr_init;
    assign restart_pwm = wr_init ? cfg_data[PWM_W-1:0] : init_reg;

    always_comb begin
        if (win_reg == '0) begin
            win_eff = CNT_W'(1);
        end else if (32'(win_reg) > 32'(MAX_ENTRIES)) begin
            win_eff = CNT_W'(MAX_ENTRIES);
        end else begin
            win_eff = CNT_W'(win_reg);
        end
    end

    assign wrap     = (32'(slot_reg) + 32'd1) >= 32'(win_eff);
    assign slot_adv = wrap ? '0 : slot_reg + 1'b1;
    assign mean_cnt = full_reg ? win_eff : CNT_W'(slot_reg) + 1'b1;
    assign sub_wide = {1'b0, target_reg} - {1'b0, s_data.actual_time};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RST;
            inc_reg    <= INC_RST;
            win_reg    <= WIN_RST;
            init_reg   <= INIT_RST;
            slot_reg   <= '0;
            full_reg   <= 1'b0;
            sum_reg    <= SUM_W'(INIT_RST);
        end else begin
            if (wr_target) begin
                target_reg <= cfg_data[TIME_W-1:0];
            end
            if (wr_inc) begin
                inc_reg <= cfg_data[PWM_W-1:0];
            end
            if (wr_win) begin
                win_reg <= cfg_data[WIN_W-1:0];
            end
            if (wr_init) begin
                init_reg <= cfg_data[PWM_W-1:0];
            end
            if (restart) begin
                slot_reg <= '0;
                full_reg <= 1'b0;
                sum_reg  <= SUM_W'(restart_pwm);
            end else begin
                if (cmd.load) begin
                    slot_reg <= slot_adv;
                    if (wrap) begin
                        full_reg <= 1'b1;
                    end
                end
                if (cmd.upd) begin
                    // full: the slot's old value leaves the window
                    sum_reg <= sum_reg - (full_reg ? SUM_W'(old_reg) : '0)
                               + SUM_W'(corr_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            diff_reg <= sub_wide[TIME_W-1:0];
            less_reg <= ~sub_wide[TIME_W] & (sub_wide[TIME_W-1:0] != '0);
            pwm_reg  <= s_data.current_pwm;
            top_reg  <= s_data.top_reached;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(pwm_reg);
        end
        if (cmd.corr) begin
            if (less_reg) begin
                corr_reg <= pwm_reg - div_q;
            end else if (!top_reg) begin
                corr_reg <= pwm_reg + inc_reg;
            end else begin
                corr_reg <= pwm_reg;
            end
        end
    end

    // reset loads entry 0 through the write port as a restart does
    always_comb begin
        ring_we    = 1'b0;
        ring_waddr = slot_reg;
        ring_wdata = corr_reg;
        if (!aresetn) begin
            ring_we    = 1'b1;
            ring_waddr = '0;
            ring_wdata = INIT_RST;
        end else if (restart) begin
            ring_we    = 1'b1;
            ring_waddr = '0;
            ring_wdata = restart_pwm;
        end else if (cmd.upd) begin
            ring_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring[ring_waddr] <= ring_wdata;
        end
        if (cmd.load) begin
            old_reg <= ring[slot_adv];
        end
    end

    // the divider is shared by the correction and the mean
    assign div_start = cmd.div_corr | cmd.div_mean;
    assign div_rem   = cmd.div_mean ? TIME_W'(sum_reg[SUM_W-1:PWM_W])
                                    : prod_reg[PROD_W-1:PWM_W];
    assign div_lo    = cmd.div_mean ? sum_reg[PWM_W-1:0] : prod_reg[PWM_W-1:0];
    assign div_den   = cmd.div_mean ? TIME_W'(mean_cnt) : target_reg;

    mptc_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start),
        .rem_init    (div_rem),
        .dividend_lo (div_lo),
        .divisor     (div_den),
        .done        (div_done),
        .quot        (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.corrected_pwm <= corr_reg;
            m_data_reg.mean_pwm      <= div_q;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign sts.div_done = div_done;
    assign sts.out_free = ~m_valid_reg | m_ready;

endmodule

// File: rtl/core/motor_pwm_time_corrector.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    in_t: actual_time, current_pwm, top_reached
// m_        out        m_valid / m_ready    out_t: corrected_pwm, mean_pwm
// cfg_      in         cfg_valid/cfg_ready  cfg_index (register), cfg_data
//
// One item at a time: each item makes two 16-step passes of the shared
// restoring divider (correction, then mean). The next item is taken the
// cycle after the result is loaded into the output register, which holds
// it while m_ready is low; a full output stalls only the final load.
// Synchronous active-low reset; both ready lines are low in reset, and registers
// accept writes on every cycle after it.
module motor_pwm_time_corrector
    import mptc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    mptc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mptc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
